FILE: rtl/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types and codes for the CAN transport receive reassembly block.
// ----------------------------------------------------------------------------
package isotp_pkg;

  // item op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // PCI type nibbles
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;
  localparam logic [3:0] PCI_FLOW   = 4'h3;

  // negative response bytes
  localparam logic [7:0] NEG_RESP_SID    = 8'h7f;
  localparam logic [7:0] NRC_BUSY_REPEAT = 8'h21;

  // item kinds as decided by the front classifier
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_FIRST  = 3'd1;
  localparam logic [2:0] KIND_CONSEC = 3'd2;
  localparam logic [2:0] KIND_IGNORE = 3'd3;
  localparam logic [2:0] KIND_SINGLE = 3'd4;

  // report codes
  localparam logic [1:0] REPORT_NONE   = 2'd0;
  localparam logic [1:0] REPORT_OK     = 2'd1;
  localparam logic [1:0] REPORT_RESEND = 2'd2;

  // completion target after reset (length 0 raised to the minimum of 13)
  localparam logic [8:0] TARGET_MIN = 9'd13;

  // classified item, front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  seq;         // sequence nibble of a consecutive frame
    logic [7:0]  new_len;     // length latched by a first or single frame
    logic [8:0]  new_target;  // completion target that goes with new_len
    logic [55:0] wbytes;      // payload bytes, first in bits 7:0
    logic [1:0]  sf_report;   // single frame report
    logic        sf_err;      // single frame error flag
  } cmd_t;

  // result item
  typedef struct packed {
    logic        accepted;
    logic [1:0]  report;
    logic        frame_error;
    logic        send_fc;
    logic [7:0]  msg_length;
    logic [7:0]  write_offset;
    logic [2:0]  write_count;
    logic [55:0] write_bytes;
  } res_t;

endpackage

FILE: rtl/isotp_rx_reassembly.sv
// ----------------------------------------------------------------------------
// isotp_rx_reassembly
// CAN transport (ISO 15765-2) receive reassembly, one 8-byte frame per item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while full is low and returns exactly one
// result per item, in order. Each item passes through the front queue, which
// holds its classified form, and the result queue, into which the back end's
// state update writes its result and from which it can be popped; a full
// result queue holds the item in the front queue. The front classifies each
// frame by its PCI nibble into a two-entry queue; the back end holds the
// reassembly state, which it updates once per cycle while the result queue
// has room, and writes into a two-entry result queue, so full rises only
// once the result queue and then the front queue have filled up.
// ----------------------------------------------------------------------------
module isotp_rx_reassembly (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [63:0] frame_data,
  output logic        empty,
  input  logic        pop,
  output logic        accepted,
  output logic [1:0]  report,
  output logic        frame_error,
  output logic        send_flow_control,
  output logic [7:0]  msg_length,
  output logic [7:0]  write_offset,
  output logic [2:0]  write_count,
  output logic [55:0] write_bytes
);

  logic             item_valid;
  logic             item_pop;
  isotp_pkg::cmd_t  item;
  isotp_pkg::res_t  res;

  // front: classify and queue
  isotp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .frame_data (frame_data),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item)
  );

  // back: state and result queue
  isotp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  // result fields
  assign accepted          = res.accepted;
  assign report            = res.report;
  assign frame_error       = res.frame_error;
  assign send_flow_control = res.send_fc;
  assign msg_length        = res.msg_length;
  assign write_offset      = res.write_offset;
  assign write_count       = res.write_count;
  assign write_bytes       = res.write_bytes;

  // back end only takes items that are there
  a_pop_valid : assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("back end took an item from an empty queue");

  // flow control request comes only with a first frame write
  a_fc_first : assert property (@(posedge clk) disable iff (rst)
    (!empty && send_flow_control) |->
      (accepted && write_count == 3'd6 && write_offset == 8'd0))
    else $error("flow control request without a first frame write");

  // an ignored frame writes and reports nothing
  a_ignored_quiet : assert property (@(posedge clk) disable iff (rst)
    (!empty && !accepted) |->
      (write_count == 3'd0 && report == isotp_pkg::REPORT_NONE && !send_flow_control))
    else $error("ignored frame produced a write or report");

  // a completed message clears the error flag
  a_ok_no_error : assert property (@(posedge clk) disable iff (rst)
    (!empty && report == isotp_pkg::REPORT_OK) |-> !frame_error)
    else $error("message complete with error flag set");

endmodule

FILE: rtl/isotp_front.sv
// ----------------------------------------------------------------------------
// isotp_front
// Classifies incoming items by PCI type, pre-slices the payload and queues
// the classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module isotp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [63:0]       frame_data,
  output logic              item_valid,
  input  logic              item_pop,
  output isotp_pkg::cmd_t   item
);

  // completion target 6 + 7*floor(max(len,13)/7); /7 by reciprocal 293/2048
  function automatic logic [8:0] calc_target(input logic [7:0] len);
    logic [7:0]  l;
    logic [16:0] prod;
    logic [5:0]  q;
    l    = (len < 8'd13) ? 8'd13 : len;
    prod = 17'(l) * 17'd293;
    q    = prod[16:11];
    return 9'd6 + {q, 3'b000} - 9'(q);
  endfunction

  logic [7:0]       pci;
  logic [7:0]       byte1;
  logic [7:0]       byte3;
  logic [2:0]       sf_len;
  logic [55:0]      sf_mask;
  isotp_pkg::cmd_t  cls;

  assign pci    = frame_data[7:0];
  assign byte1  = frame_data[15:8];
  assign byte3  = frame_data[31:24];
  assign sf_len = pci[2:0];

  // byte mask for a single frame payload
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      sf_mask[8*k +: 8] = (3'(k) < sf_len) ? 8'hff : 8'h00;
    end
  end

  // classify
  always_comb begin
    cls            = '0;
    cls.seq        = pci[3:0];
    cls.new_target = isotp_pkg::TARGET_MIN;
    cls.sf_report  = isotp_pkg::REPORT_NONE;
    if (op == isotp_pkg::OP_START) begin
      cls.kind = isotp_pkg::KIND_START;
    end else begin
      unique case (pci[7:4])
        isotp_pkg::PCI_FIRST: begin
          cls.kind       = isotp_pkg::KIND_FIRST;
          cls.new_len    = byte1;
          cls.new_target = calc_target(byte1);
          cls.wbytes     = {8'h00, frame_data[63:16]};
        end
        isotp_pkg::PCI_CONSEC: begin
          cls.kind   = isotp_pkg::KIND_CONSEC;
          cls.wbytes = frame_data[63:8];
        end
        isotp_pkg::PCI_FLOW: begin
          cls.kind = isotp_pkg::KIND_IGNORE;
        end
        default: begin
          cls.kind    = isotp_pkg::KIND_SINGLE;
          cls.new_len = {5'd0, sf_len};
          cls.wbytes  = frame_data[63:8] & sf_mask;
          // negative response: busy-repeat code asks for a resend
          if (byte1 != isotp_pkg::NEG_RESP_SID) begin
            cls.sf_err    = 1'b0;
            cls.sf_report = isotp_pkg::REPORT_OK;
          end else begin
            cls.sf_err    = 1'b1;
            cls.sf_report = (byte3 == isotp_pkg::NRC_BUSY_REPEAT) ? isotp_pkg::REPORT_RESEND
                                                                  : isotp_pkg::REPORT_NONE;
          end
        end
      endcase
    end
  end

  // two-entry queue toward the back end
  isotp_pkg::cmd_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;

  assign do_push    = push && !full;
  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (item_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(item_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cls;
  end

endmodule

FILE: rtl/isotp_back.sv
// ----------------------------------------------------------------------------
// isotp_back
// Holds the reassembly state, carries out one classified item per cycle while
// the result queue has room, and queues the results in a two-entry result queue.
// ----------------------------------------------------------------------------
module isotp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  isotp_pkg::cmd_t   item,
  output logic              item_pop,
  output logic              empty,
  input  logic              pop,
  output isotp_pkg::res_t   res
);

  // reassembly state
  logic [7:0] expected_length, expected_length_next;
  logic [8:0] target, target_next;
  logic [7:0] data_count, data_count_next;
  logic [3:0] seq_expected, seq_expected_next;
  logic       length_known, length_known_next;
  logic       error_flag, error_flag_next;

  isotp_pkg::res_t rq [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_pop;
  isotp_pkg::res_t r;
  logic [8:0]      sum;

  assign do_pop   = pop && !empty;
  assign empty    = (count == 2'd0);
  assign item_pop = item_valid && ((count != 2'd2) || do_pop);
  assign res      = rq[rd_ptr];
  assign sum      = 9'(data_count) + 9'd7;

  // execute the head item
  always_comb begin
    expected_length_next = expected_length;
    target_next          = target;
    data_count_next      = data_count;
    seq_expected_next    = seq_expected;
    length_known_next    = length_known;
    error_flag_next      = error_flag;
    r                    = '0;
    r.accepted           = 1'b1;
    r.report             = isotp_pkg::REPORT_NONE;
    unique case (item.kind)
      isotp_pkg::KIND_START: begin
        data_count_next   = 8'd0;
        seq_expected_next = 4'd0;
        length_known_next = 1'b0;
        error_flag_next   = 1'b0;
      end
      isotp_pkg::KIND_FIRST: begin
        expected_length_next = item.new_len;
        target_next          = item.new_target;
        length_known_next    = 1'b1;
        data_count_next      = 8'd6;
        seq_expected_next    = 4'd1;
        error_flag_next      = 1'b1;
        r.send_fc            = 1'b1;
        r.write_count        = 3'd6;
        r.write_bytes        = item.wbytes;
      end
      isotp_pkg::KIND_CONSEC: begin
        if (!length_known || (seq_expected != item.seq)) begin
          r.accepted = 1'b0;
        end else begin
          seq_expected_next = seq_expected + 4'd1;
          data_count_next   = sum[8] ? 8'hff : sum[7:0];
          r.write_offset    = data_count;
          r.write_count     = 3'd7;
          r.write_bytes     = item.wbytes;
          // completion check against the rounded length
          if (target != 9'(data_count_next)) begin
            error_flag_next = 1'b1;
          end else begin
            error_flag_next = 1'b0;
            r.report        = isotp_pkg::REPORT_OK;
          end
        end
      end
      isotp_pkg::KIND_SINGLE: begin
        expected_length_next = item.new_len;
        target_next          = item.new_target;
        error_flag_next      = item.sf_err;
        r.report             = item.sf_report;
        r.write_count        = item.new_len[2:0];
        r.write_bytes        = item.wbytes;
      end
      default: begin
        r.accepted = 1'b0;
      end
    endcase
    r.frame_error = error_flag_next;
    r.msg_length  = expected_length_next;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 8'd0;
      target          <= isotp_pkg::TARGET_MIN;
      data_count      <= 8'd0;
      seq_expected    <= 4'd0;
      length_known    <= 1'b0;
      error_flag      <= 1'b0;
    end else if (item_pop) begin
      expected_length <= expected_length_next;
      target          <= target_next;
      data_count      <= data_count_next;
      seq_expected    <= seq_expected_next;
      length_known    <= length_known_next;
      error_flag      <= error_flag_next;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (item_pop) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(item_pop) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) rq[wr_ptr] <= r;
  end

endmodule

FILE: test/isotp_rx_reassembly_test.sv
// ----------------------------------------------------------------------------
// isotp_rx_reassembly_test
// Self-checking bench for the CAN transport receive reassembly block.
// ----------------------------------------------------------------------------
// Frames go in through the push/full side and results come out through the
// empty/pop side, with random gaps on both sides. A scoreboard tracks the
// reassembly state on its own, predicts one result per transferred frame and
// compares every popped result field by field. A short directed run covers
// the frame types, negative responses and the short-length case. Random
// messages follow, first frame plus consecutive frames with occasional
// faults, mixed with single frames, starts and noise.
// ----------------------------------------------------------------------------
module isotp_rx_reassembly_test;

  // item op codes
  localparam logic OP_START = isotp_pkg::OP_START;
  localparam logic OP_FRAME = isotp_pkg::OP_FRAME;

  // PCI type nibbles
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = isotp_pkg::PCI_FIRST;
  localparam logic [3:0] PCI_CONSEC = isotp_pkg::PCI_CONSEC;
  localparam logic [3:0] PCI_FLOW   = isotp_pkg::PCI_FLOW;

  // negative response bytes
  localparam logic [7:0] NEG_SID  = isotp_pkg::NEG_RESP_SID;
  localparam logic [7:0] NRC_BUSY = isotp_pkg::NRC_BUSY_REPEAT;

  localparam int MIN_LEN     = 13;
  localparam int RAND_FRAMES = 1750;
  localparam int HOLD_CYCLES = 80;

  // --------------------------------------------------------------------------
  // scoreboard: private copy of the reassembly state plus expected results
  // --------------------------------------------------------------------------
  class reassembly_scoreboard;
    logic [7:0] msg_len   = '0;
    logic [7:0] byte_cnt  = '0;
    logic [3:0] next_seq  = '0;
    logic       len_known = 1'b0;
    logic       err_flag  = 1'b0;
    isotp_pkg::res_t pending_results[$];
    int         fail_count = 0;

    // predict the result of one transferred frame
    function void note_frame(logic o, logic [63:0] d);
      isotp_pkg::res_t r;
      logic [7:0]  pci;
      logic [55:0] keep;
      int          len;
      int          target;
      int          sum;
      r = '0;
      r.accepted = 1'b1;
      pci = d[7:0];
      if (o == OP_START) begin
        byte_cnt  = '0;
        next_seq  = '0;
        len_known = 1'b0;
        err_flag  = 1'b0;
      end else begin
        case (pci[7:4])
          PCI_FIRST: begin
            msg_len       = d[15:8];
            len_known     = 1'b1;
            r.write_count = 3'd6;
            r.write_bytes = {8'h00, d[63:16]};
            byte_cnt      = 8'd6;
            r.send_fc     = 1'b1;
            err_flag      = 1'b1;
            next_seq      = 4'd1;
          end
          PCI_CONSEC: begin
            if (!len_known || next_seq != pci[3:0]) begin
              r.accepted = 1'b0;
            end else begin
              // completion target: length raised to the minimum, then 6+7k
              len = int'(msg_len);
              if (len < MIN_LEN) len = MIN_LEN;
              target         = 6 + 7 * (len / 7);
              next_seq       = next_seq + 4'd1;
              r.write_offset = byte_cnt;
              r.write_count  = 3'd7;
              r.write_bytes  = d[63:8];
              sum            = int'(byte_cnt) + 7;
              byte_cnt       = (sum > 255) ? 8'hff : sum[7:0];
              if (target != int'(byte_cnt)) begin
                err_flag = 1'b1;
              end else begin
                err_flag = 1'b0;
                r.report = isotp_pkg::REPORT_OK;
              end
            end
          end
          PCI_FLOW: begin
            r.accepted = 1'b0;
          end
          default: begin
            // everything else is a single frame
            msg_len       = {5'b0, pci[2:0]};
            r.write_count = pci[2:0];
            keep          = (56'h1 << (8 * pci[2:0])) - 56'h1;
            r.write_bytes = d[63:8] & keep;
            err_flag      = 1'b1;
            if (d[15:8] != NEG_SID) begin
              err_flag = 1'b0;
              r.report = isotp_pkg::REPORT_OK;
            end else if (d[31:24] == NRC_BUSY) begin
              r.report = isotp_pkg::REPORT_RESEND;
            end
          end
        endcase
      end
      r.frame_error = err_flag;
      r.msg_length  = msg_len;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    // compare one popped result with the oldest prediction
    function void check_result(isotp_pkg::res_t got);
      isotp_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result popped with no frame waiting");
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("report", want.report, got.report);
      compare_field("frame_error", want.frame_error, got.frame_error);
      compare_field("send_flow_control", want.send_fc, got.send_fc);
      compare_field("msg_length", want.msg_length, got.msg_length);
      compare_field("write_offset", want.write_offset, got.write_offset);
      compare_field("write_count", want.write_count, got.write_count);
      compare_field("write_bytes", want.write_bytes, got.write_bytes);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        op = 1'b0;
  logic [63:0] frame_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        accepted;
  logic [1:0]  report;
  logic        frame_error;
  logic        send_flow_control;
  logic [7:0]  msg_length;
  logic [7:0]  write_offset;
  logic [2:0]  write_count;
  logic [55:0] write_bytes;

  reassembly_scoreboard sb = new;
  int sent_count = 0;

  isotp_rx_reassembly u_dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .op                (op),
    .frame_data        (frame_data),
    .empty             (empty),
    .pop               (pop),
    .accepted          (accepted),
    .report            (report),
    .frame_error       (frame_error),
    .send_flow_control (send_flow_control),
    .msg_length        (msg_length),
    .write_offset      (write_offset),
    .write_count       (write_count),
    .write_bytes       (write_bytes)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // frame builders
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] first_frame(input logic [7:0] len);
    logic [63:0] d;
    d = rand_data();
    d[7:4]  = PCI_FIRST;
    d[15:8] = len;
    return d;
  endfunction

  function automatic logic [63:0] consec_frame(input logic [3:0] seq);
    logic [63:0] d;
    d = rand_data();
    d[7:0] = {PCI_CONSEC, seq};
    return d;
  endfunction

  function automatic logic [63:0] flow_frame();
    logic [63:0] d;
    d = rand_data();
    d[7:4] = PCI_FLOW;
    return d;
  endfunction

  // single frame with any of the non-transport nibbles 0, 4..F
  function automatic logic [63:0] single_frame(input logic neg, input logic busy);
    logic [63:0] d;
    int          nib;
    d = rand_data();
    nib = $urandom_range(12);
    d[7:4] = (nib == 0) ? PCI_SINGLE : 4'(nib + 3);
    if (neg) d[15:8] = NEG_SID;
    if (busy) d[31:24] = NRC_BUSY;
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // input side: offer one frame, hold it until the transfer
  // --------------------------------------------------------------------------
  task automatic send_item(input logic o, input logic [63:0] d);
    if (sent_count < 700 || sent_count >= 1000) begin
      while ($urandom_range(99) < 21) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push       <= 1'b1;
    op         <= o;
    frame_data <= d;
    do @(posedge clk); while (full);
    sb.note_frame(o, d);
    sent_count++;
  endtask

  // one message: first frame, then in-order consecutive frames with faults
  task automatic send_message(input int len);
    int         len_c;
    int         target;
    int         n;
    int         k;
    int         r;
    logic [3:0] seq;
    len_c  = (len < MIN_LEN) ? MIN_LEN : len;
    target = 6 + 7 * (len_c / 7);
    n      = (target > 255) ? 37 : (target - 6) / 7;
    if ($urandom_range(1)) send_item(OP_START, rand_data());
    send_item(OP_FRAME, first_frame(8'(len)));
    seq = 4'd1;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 1) begin
        // abort mid-message
        send_item(OP_START, rand_data());
        break;
      end
      if (r < 4) send_item(OP_FRAME, consec_frame(seq + 4'($urandom_range(15, 1))));
      else if (r < 6) send_item(OP_FRAME, flow_frame());
      send_item(OP_FRAME, consec_frame(seq));
      seq = seq + 4'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random pops, one long hold-off, one stretch with no gaps
  // --------------------------------------------------------------------------
  initial begin
    int              got_count;
    bit              held;
    isotp_pkg::res_t got;
    got_count = 0;
    held      = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got = {accepted, report, frame_error, send_flow_control, msg_length,
               write_offset, write_count, write_bytes};
        sb.check_result(got);
        got_count++;
      end
      if (got_count >= 400 && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= (got_count >= 1100 && got_count < 1400) || ($urandom_range(99) >= 21);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int lp;
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: frame types and data extremes
    send_item(OP_START, '1);
    send_item(OP_FRAME, 64'h0);
    send_item(OP_FRAME, '1);
    send_item(OP_FRAME, 64'h1122_3344_5566_7747);
    // negative responses: busy-repeat, other code, busy with length zero
    send_item(OP_FRAME, 64'haaaa_aaaa_2110_7ff3);
    send_item(OP_FRAME, 64'h5555_5555_3131_7f05);
    send_item(OP_FRAME, 64'h0000_0000_2100_7f00);
    send_item(OP_FRAME, 64'h0000_0000_0000_0030);
    // consecutive frame before any first frame
    send_item(OP_START, 64'h0);
    send_item(OP_FRAME, 64'h8877_6655_4433_2221);
    // short length raised to the minimum, completes after one frame
    send_item(OP_FRAME, 64'hf0e0_d0c0_b0a0_0510);
    send_item(OP_FRAME, 64'h0102_0304_0506_0721);
    send_item(OP_FRAME, 64'h0102_0304_0506_0725);
    // length zero, all-ones payload
    send_item(OP_FRAME, 64'hffff_ffff_ffff_001f);
    send_item(OP_FRAME, 64'hffff_ffff_ffff_ff21);
    // length 20: one frame short, then complete
    send_item(OP_FRAME, first_frame(8'd20));
    send_item(OP_FRAME, consec_frame(4'd1));
    send_item(OP_FRAME, consec_frame(4'd2));
    // abort after a first frame
    send_item(OP_FRAME, first_frame(8'd13));
    send_item(OP_START, rand_data());
    send_item(OP_FRAME, consec_frame(4'd1));

    // random traffic, mostly well-formed messages
    while (sent_count < RAND_FRAMES) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        lp = $urandom_range(99);
        if (lp < 80) len = $urandom_range(60);
        else if (lp < 95) len = $urandom_range(251, 61);
        else len = $urandom_range(255, 252);
        send_message(len);
      end else if (pick < 70) begin
        send_item(OP_FRAME, single_frame(1'($urandom_range(1)), 1'($urandom_range(1))));
      end else if (pick < 78) begin
        send_item(OP_START, rand_data());
      end else if (pick < 88) begin
        send_item(1'($urandom_range(1)), rand_data());
      end else if (pick < 94) begin
        send_item(OP_FRAME, consec_frame(4'($urandom_range(15))));
      end else begin
        send_item(OP_FRAME, flow_frame());
      end
    end
    push <= 1'b0;

    // drain, then wait for stray results
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(100000 * 12);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/isotp_pkg.sv
rtl/isotp_front.sv
rtl/isotp_back.sv
rtl/isotp_rx_reassembly.sv
test/isotp_rx_reassembly_test.sv
